FILE: design/sha224_pkg.sv
package sha224_pkg;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
	} out_item_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] H_INIT [8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

endpackage

FILE: design/sha224_if.sv
interface sha224_in_if;
	logic                 valid;
	logic                 ready;
	sha224_pkg::in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sha224_out_if;
	logic                  valid;
	logic                  ready;
	sha224_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/sha224_round.sv
module sha224_round (
	input  logic [31:0] a, b, c, d, e, f, g, h,
	input  logic [31:0] k,
	input  logic [31:0] w,
	output logic [31:0] a_n,
	output logic [31:0] e_n
);
	logic [31:0] big0, big1, ch, maj, t1;

	always_comb begin
		big1 = sha224_pkg::ror(e, 6) ^ sha224_pkg::ror(e, 11) ^ sha224_pkg::ror(e, 25);
		ch   = (e & f) ^ (~e & g);
		t1   = h + big1 + ch + k + w;
		big0 = sha224_pkg::ror(a, 2) ^ sha224_pkg::ror(a, 13) ^ sha224_pkg::ror(a, 22);
		maj  = (a & b) ^ (a & c) ^ (b & c);
		a_n  = t1 + big0 + maj;
		e_n  = d + t1;
	end
endmodule

FILE: design/sha224_hash_engine.sv
// SHA-224 byte-stream engine with the message block and chaining words in memories.
// While filling, each offered byte is accepted; the byte that fills a block starts
// a busy phase (load, round, chain-update) during which no item is accepted.
// End of message: a padding pass and the final block come before the first digest item,
// and a second pass and block follow when the length needs a block of its own.
// Asynchronous active-low reset restores the start values and empties the block.
module sha224_hash_engine (
	input  logic clk,
	input  logic arst_n,
	sha224_in_if.sink   in_ch,
	sha224_out_if.source out_ch
);
	// The block buffer holds 16 big-endian message words; it is written one byte
	// at a time through a read-modify-free byte-lane write.
	logic [31:0] blk_mem [16];
	// Chaining words live in a small memory, read by the loader, the chain-update pass and the digest output.
	logic [31:0] chain_mem [8];

	sha224_pkg::state_t state_q, state_d;

	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        fin_q;     // message closed, padding in progress
	logic        lenblk_q;  // current block carries the length
	logic        pad80_q;   // 0x80 already placed
	logic [5:0]  pad_q;
	logic [5:0]  rnd_q;
	logic [3:0]  idx_q;
	logic        chain_init_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0] w_q [16];
	logic [31:0] chain_rd_s1;
	logic [31:0] out_word_q;
	logic [2:0]  out_num_q;
	logic        out_valid_q;

	logic [31:0] a_n, e_n, w_cur, w_new, s0, s1;

	logic        accept;
	logic        byte_wr;
	logic [5:0]  byte_addr;
	logic [7:0]  byte_val;

	assign accept = in_ch.valid && in_ch.ready;

	sha224_round u_round (
		.a(a_q), .b(b_q), .c(c_q), .d(d_q), .e(e_q), .f(f_q), .g(g_q), .h(h_q),
		.k(sha224_pkg::K_TAB[rnd_q]), .w(w_cur), .a_n(a_n), .e_n(e_n)
	);

	// Message schedule in a 16-word shifting window.
	always_comb begin
		s0 = sha224_pkg::ror(w_q[1], 7) ^ sha224_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha224_pkg::ror(w_q[14], 17) ^ sha224_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		w_cur = w_q[0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha224_pkg::ST_FILL: begin
				if (accept) begin
					if (in_ch.payload.byte_present && fill_q == 6'd63) begin
						state_d = sha224_pkg::ST_LOAD;
					end else if (in_ch.payload.end_of_message) begin
						state_d = sha224_pkg::ST_PAD;
					end
				end
			end
			sha224_pkg::ST_PAD: begin
				if (pad_q == 6'd63) state_d = sha224_pkg::ST_LOAD;
			end
			sha224_pkg::ST_LOAD: begin
				if (idx_q == 4'd8) state_d = sha224_pkg::ST_ROUND;
			end
			sha224_pkg::ST_ROUND: begin
				if (rnd_q == 6'd63) state_d = sha224_pkg::ST_ADD;
			end
			sha224_pkg::ST_ADD: begin
				if (idx_q == 4'd8) begin
					if (lenblk_q) state_d = sha224_pkg::ST_EMIT;
					else if (fin_q) state_d = sha224_pkg::ST_PAD;
					else state_d = sha224_pkg::ST_FILL;
				end
			end
			sha224_pkg::ST_EMIT: begin
				if (out_valid_q && out_ch.ready && out_num_q == 3'd6)
					state_d = sha224_pkg::ST_FILL;
			end
			default: state_d = sha224_pkg::ST_FILL;
		endcase
	end

	// Byte writes into the block buffer, from input or the padding sequencer.
	// The first padding pass leaves the message bytes below the fill level alone.
	always_comb begin
		byte_wr   = 1'b0;
		byte_addr = pad_q;
		byte_val  = 8'h00;
		unique case (state_q)
			sha224_pkg::ST_FILL: begin
				byte_wr   = accept && in_ch.payload.byte_present;
				byte_addr = fill_q;
				byte_val  = in_ch.payload.data_byte;
			end
			sha224_pkg::ST_PAD: begin
				byte_wr = pad80_q || (pad_q >= fill_q);
				if (!pad80_q && pad_q == fill_q) byte_val = sha224_pkg::PAD_BYTE;
				else if (lenblk_q && pad_q >= 6'd56)
					byte_val = bits_q[8 * (63 - pad_q) +: 8];
				else byte_val = 8'h00;
			end
			default: byte_wr = 1'b0;
		endcase
	end

	assign in_ch.ready = (state_q == sha224_pkg::ST_FILL);

	always_ff @(posedge clk) begin
		if (byte_wr) blk_mem[byte_addr[5:2]][8 * (3 - byte_addr[1:0]) +: 8] <= byte_val;
	end

	// Chain memory: registered read, one write port.
	always_ff @(posedge clk) begin
		chain_rd_s1 <= chain_init_q ? sha224_pkg::H_INIT[idx_q[2:0]] : chain_mem[idx_q[2:0]];
		if (state_q == sha224_pkg::ST_ADD && idx_q != 4'd0) begin
			chain_mem[idx_q[2:0] - 3'd1] <= chain_rd_s1 + a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sha224_pkg::ST_FILL;
			fill_q       <= '0;
			bits_q       <= '0;
			fin_q        <= 1'b0;
			lenblk_q     <= 1'b0;
			pad80_q      <= 1'b0;
			pad_q        <= '0;
			rnd_q        <= '0;
			idx_q        <= '0;
			chain_init_q <= 1'b1;
			out_valid_q  <= 1'b0;
			out_num_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sha224_pkg::ST_FILL: begin
					if (accept && in_ch.payload.byte_present) begin
						fill_q <= fill_q + 6'd1;
						bits_q <= bits_q + 64'd8;
					end
					if (accept && in_ch.payload.end_of_message) fin_q <= 1'b1;
					if (accept && in_ch.payload.end_of_message &&
							!(in_ch.payload.byte_present && fill_q == 6'd63)) begin
						pad_q    <= '0;
						lenblk_q <= (fill_q + {5'd0, in_ch.payload.byte_present}) < 6'd56;
					end
					rnd_q <= '0;
					idx_q <= '0;
				end
				sha224_pkg::ST_PAD: begin
					if (!pad80_q && pad_q == fill_q) pad80_q <= 1'b1;
					pad_q <= pad_q + 6'd1;
					rnd_q <= '0;
					idx_q <= '0;
				end
				sha224_pkg::ST_LOAD: begin
					idx_q <= (idx_q == 4'd8) ? 4'd0 : idx_q + 4'd1;
					rnd_q <= '0;
				end
				sha224_pkg::ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					idx_q <= '0;
				end
				sha224_pkg::ST_ADD: begin
					idx_q <= (idx_q == 4'd8) ? 4'd0 : idx_q + 4'd1;
					if (idx_q == 4'd8) begin
						chain_init_q <= 1'b0;
						pad_q        <= '0;
						// The next pass carries the length; a message that ended on a full block also still needs its 0x80.
						if (fin_q && !lenblk_q) lenblk_q <= 1'b1;
						if (lenblk_q) begin
							out_valid_q <= 1'b1;
							out_num_q   <= '0;
						end
					end
				end
				sha224_pkg::ST_EMIT: begin
					if (out_valid_q && out_ch.ready) begin
						out_num_q <= out_num_q + 3'd1;
						if (out_num_q == 3'd6) begin
							out_valid_q  <= 1'b0;
							fill_q       <= '0;
							bits_q       <= '0;
							fin_q        <= 1'b0;
							lenblk_q     <= 1'b0;
							pad80_q      <= 1'b0;
							chain_init_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Working variables and the schedule window. The load pass shifts the chain
	// words in at h so that a ends up with word 0; the add pass shifts them out at a.
	always_ff @(posedge clk) begin
		if (state_q == sha224_pkg::ST_LOAD) begin
			if (idx_q == 4'd0) begin
				for (int i = 0; i < 16; i++) w_q[i] <= blk_mem[i];
			end else begin
				{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <=
					{b_q, c_q, d_q, e_q, f_q, g_q, h_q, chain_rd_s1};
			end
		end
		if (state_q == sha224_pkg::ST_ROUND) begin
			{a_q, b_q, c_q, d_q} <= {a_n, a_q, b_q, c_q};
			{e_q, f_q, g_q, h_q} <= {e_n, e_q, f_q, g_q};
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end
		if (state_q == sha224_pkg::ST_ADD && idx_q != 4'd0) begin
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <=
				{b_q, c_q, d_q, e_q, f_q, g_q, h_q, 32'd0};
		end
		// Outside the digest phase word 0 is kept ready for the first digest item.
		out_word_q <= chain_mem[(state_q == sha224_pkg::ST_EMIT) ?
			out_num_q + ((out_valid_q && out_ch.ready) ? 3'd1 : 3'd0) : 3'd0];
	end

	assign out_ch.valid                   = out_valid_q && (state_q == sha224_pkg::ST_EMIT);
	assign out_ch.payload.digest_word     = out_word_q;
	assign out_ch.payload.word_number     = out_num_q;
	assign out_ch.payload.last_word       = (out_num_q == 3'd6);

`ifndef SYNTHESIS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != sha224_pkg::ST_FILL |-> !in_ch.ready)
		else $error("input accepted while busy");
	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_num_q != 3'd7)
		else $error("digest word number out of range");
`endif
endmodule

FILE: test/sha224_hash_engine_tb.sv
module sha224_hash_engine_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_ITEMS = 24;

	logic clk;
	logic arst_n;
	sha224_in_if in_ch ();
	sha224_out_if out_ch ();

	sha224_hash_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Predictor state: a software copy of the chaining words, the partial block,
	// its fill level and the running bit length of the message.
	logic [31:0] chain_model [8];
	logic [7:0] block_model [64];
	int unsigned fill_model;
	logic [63:0] bits_model;

	// Digest words still owed by the engine, oldest first.
	sha224_pkg::out_item_t digest_queue [$];

	int fail_count;
	bit stim_done;
	bit hold_off;
	bit valid_up;
	int idle_cycles;
	int msg_len;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress_model();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {block_model[4*t], block_model[4*t+1], block_model[4*t+2],
				block_model[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		v = chain_model;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha224_pkg::K_TAB[t] + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_model[i] += v[i];
	endtask

	task automatic clear_model();
		chain_model = sha224_pkg::H_INIT;
		fill_model = 0;
		bits_model = '0;
	endtask

	// Advances the predictor by one accepted item and queues any digest words.
	task automatic absorb_item(input sha224_pkg::in_item_t it);
		int unsigned pos;
		sha224_pkg::out_item_t o;
		if (it.byte_present) begin
			block_model[fill_model] = it.data_byte;
			bits_model += 64'd8;
			fill_model++;
			if (fill_model == 64) begin
				compress_model();
				fill_model = 0;
			end
		end
		if (it.end_of_message) begin
			pos = fill_model;
			block_model[pos++] = sha224_pkg::PAD_BYTE;
			if (pos > 56) begin
				while (pos < 64) block_model[pos++] = 8'h00;
				compress_model();
				pos = 0;
			end
			while (pos < 56) block_model[pos++] = 8'h00;
			for (int i = 0; i < 8; i++)
				block_model[56+i] = bits_model[63-8*i -: 8];
			compress_model();
			for (int i = 0; i < 7; i++) begin
				o.digest_word = chain_model[i];
				o.word_number = 3'(i);
				o.last_word = (i == 6);
				digest_queue.push_back(o);
			end
			clear_model();
		end
	endtask

	// Directed rows. Where a digest is known by heart, its first word is written in the row
	// and compared in addition to the predictor.
	typedef struct {
		sha224_pkg::in_item_t it;
		bit                   known;
		logic [31:0]          first_word;
	} row_t;

	row_t directed [$];

	function automatic row_t mk(input logic [7:0] b, input bit p, input bit e,
		input bit known = 0, input logic [31:0] w0 = '0);
		row_t r;
		r.it.data_byte = b;
		r.it.byte_present = p;
		r.it.end_of_message = e;
		r.known = known;
		r.first_word = w0;
		return r;
	endfunction

	// Lowers valid once, only if it is up.
	task automatic drop_valid();
		if (valid_up) begin
			in_ch.valid <= 1'b0;
			valid_up = 1'b0;
		end
	endtask

	// Sends one item, optionally after a random gap, and feeds the predictor
	// the moment it is accepted. Valid stays up for a back-to-back follower.
	task automatic send_item(input sha224_pkg::in_item_t it, input bit gaps);
		int gap;
		gap = 0;
		if (gaps) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0) gap = 0;
		end
		if (gap > 0) begin
			drop_valid();
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		valid_up = 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		absorb_item(it);
	endtask

	task automatic wait_drained();
		if (digest_queue.size() != 0) begin
			drop_valid();
			while (digest_queue.size() != 0) @(posedge clk);
		end
	endtask

	sha224_pkg::in_item_t rnd;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		fail_count = 0;
		stim_done = 0;
		hold_off = 0;
		valid_up = 0;
		clear_model();
		for (int i = 0; i < 64; i++) block_model[i] = 8'h00;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The empty message has the well known digest beginning d14a028c.
		directed.push_back(mk(8'h00, 0, 0));
		directed.push_back(mk(8'h00, 0, 1, 1, 32'hd14a028c));
		// "abc" in one go, the last byte carrying the end mark.
		directed.push_back(mk(8'h61, 1, 0));
		directed.push_back(mk(8'h62, 1, 0));
		directed.push_back(mk(8'h63, 1, 1, 1, 32'h23097d22));
		// Field extremes, an idle step mid-message, an end without a byte, and two one-byte messages.
		directed.push_back(mk(8'hff, 1, 0));
		directed.push_back(mk(8'h00, 0, 0));
		directed.push_back(mk(8'h00, 1, 0));
		directed.push_back(mk(8'hff, 0, 1));
		directed.push_back(mk(8'h55, 1, 1));
		directed.push_back(mk(8'haa, 1, 1));

		foreach (directed[k]) begin
			if (directed[k].known && digest_queue.size() != 0) wait_drained();
			send_item(directed[k].it, 1'b0);
			if (directed[k].known && digest_queue[0].digest_word != directed[k].first_word) begin
				$error("digest_word: expected %h, actual %h", directed[k].first_word,
					digest_queue[0].digest_word);
				fail_count++;
			end
		end

		// A 56-byte message needs a second block for its length; a 64-byte one
		// closes with the byte that fills the block.
		for (int k = 0; k < 2; k++) begin
			msg_len = (k == 0) ? 56 : 64;
			for (int i = 0; i < msg_len; i++) begin
				rnd.data_byte = 8'($urandom);
				rnd.byte_present = 1'b1;
				rnd.end_of_message = (i == msg_len - 1);
				send_item(rnd, 1'b1);
			end
		end

		// The sender pauses here until every digest word has come back.
		wait_drained();

		// Random messages: mostly bytes, an occasional idle, a short end. The item
		// sent with the hold-off closes a message so that the digest backs up.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			rnd.data_byte = 8'($urandom);
			rnd.byte_present = ($urandom_range(0, 9) != 0);
			rnd.end_of_message = ($urandom_range(0, 11) == 0);
			if (n == RANDOM_ITEMS / 2) begin
				hold_off = 1;
				rnd.end_of_message = 1'b1;
			end
			send_item(rnd, (n % 40) < 30);
		end
		rnd.data_byte = 8'h00;
		rnd.byte_present = 1'b0;
		rnd.end_of_message = 1'b1;
		send_item(rnd, 1'b0);
		drop_valid();
		stim_done = 1;
	end

	// Receiver: random stalls, plus one long hold-off that backs up the digest.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_off) begin
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 19) == 0) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		wait (hold_off);
		repeat (400) @(posedge clk);
		hold_off = 0;
	end

	// Result check against the oldest queued digest word.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (digest_queue.size() == 0) begin
				$error("unexpected digest item %h", out_ch.payload.digest_word);
				fail_count++;
			end else begin
				if (out_ch.payload.digest_word !== digest_queue[0].digest_word) begin
					$error("digest_word: expected %h, actual %h",
						digest_queue[0].digest_word, out_ch.payload.digest_word);
					fail_count++;
				end
				if (out_ch.payload.word_number !== digest_queue[0].word_number) begin
					$error("word_number: expected %0d, actual %0d",
						digest_queue[0].word_number, out_ch.payload.word_number);
					fail_count++;
				end
				if (out_ch.payload.last_word !== digest_queue[0].last_word) begin
					$error("last_word: expected %0d, actual %0d",
						digest_queue[0].last_word, out_ch.payload.last_word);
					fail_count++;
				end
				void'(digest_queue.pop_front());
			end
		end
	end

	// Watchdog and end of run.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("sha224_hash_engine_tb NOT OK");
				$finish;
			end
			if (stim_done && digest_queue.size() == 0) begin
				repeat (DRAIN_CYCLES) @(posedge clk);
				if (fail_count == 0 && digest_queue.size() == 0) begin
					$display("sha224_hash_engine_tb OK");
				end else begin
					$display("sha224_hash_engine_tb NOT OK");
				end
				$finish;
			end
		end
	end

endmodule
